// ===== hw/rtl/bms_pkg.sv =====
// ----------------------------------------------------------------------------
// bms_pkg
// Shared constants and helpers for the bitmap sorter: bitmap geometry,
// field widths and the lowest-set-bit encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bms_pkg;

    localparam int unsigned RANGE_BITS = 65536;
    localparam int unsigned VAL_W      = 24;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned BIT_W      = $clog2(WORD_W);
    localparam int unsigned IDX_W      = $clog2(RANGE_BITS);
    localparam int unsigned CUR_W      = IDX_W + 1;
    localparam int unsigned WORD_CNT   = (RANGE_BITS + WORD_W - 1) / WORD_W;
    localparam int unsigned WADDR_W    = (WORD_CNT > 1) ? $clog2(WORD_CNT) : 1;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_FETCH  = 1'b1;

    // Position of the lowest set bit; zero when the word is empty.
    function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (w[i]) begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bms_ram.sv =====
// ----------------------------------------------------------------------------
// bms_ram
// Bitmap storage: one word per address, one write port and one read port
// with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bms_ram
    import bms_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic [WADDR_W-1:0] i_waddr,
    input  wire logic [WORD_W-1:0]  i_wdata,
    input  wire logic [WADDR_W-1:0] i_raddr,
    output logic      [WORD_W-1:0]  o_rdata
);

    logic [WORD_W-1:0] mem [WORD_CNT];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_sort.sv =====
// ----------------------------------------------------------------------------
// bitmap_sort
// Bit-vector sort of distinct values: inserts set presence bits, fetches
// return the stored values in ascending order.
// ----------------------------------------------------------------------------
// After reset the block sweeps the bitmap RAM to zero, one 32-bit word per
// cycle, with o_busy high; base_offset writes are taken during the sweep. An
// in-range insert issues the word read when accepted, then o_busy is high for
// 1 cycle while the word is written back; other inserts are dropped. A fetch
// issues the read of the cursor's word when accepted, then holds o_busy high
// while it examines bitmap words from the cursor's word up to the word holding
// the next set bit, or the last word (up to 2048 words); the RAM's single read
// port delivers one word per cycle. A fetch after the scan has ended never
// raises o_busy. Each fetch result appears on o_sorted_value/o_found with
// o_strobe for exactly one cycle, the cycle after the last word is examined,
// and is not held: the receiver must take it then. Inserts give no result.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_sort
    import bms_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    output logic                  o_busy,
    input  wire logic             i_kind,
    input  wire logic [VAL_W-1:0] i_value,
    input  wire logic             i_cfg_we,
    input  wire logic [VAL_W-1:0] i_cfg_data,
    output logic                  o_strobe,
    output logic      [VAL_W-1:0] o_sorted_value,
    output logic                  o_found
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INS,
        S_SCAN
    } t_state;

    t_state             r_state;
    logic [WADDR_W-1:0] r_clr_addr;
    logic [CUR_W-1:0]   r_cursor;
    logic [IDX_W-1:0]   r_ins_idx;
    logic [WADDR_W-1:0] r_chk_word;
    logic               r_first;
    logic [VAL_W-1:0]   r_base;
    logic               r_strobe;
    logic [VAL_W-1:0]   r_sorted;
    logic               r_found;

    logic               accept;
    logic [VAL_W:0]     diff;
    logic               ins_ok;
    logic [WADDR_W-1:0] raddr;
    logic [WORD_W-1:0]  rdata;
    logic               we;
    logic [WADDR_W-1:0] waddr;
    logic [WORD_W-1:0]  wdata;
    logic [WORD_W-1:0]  masked;
    logic [BIT_W-1:0]   hit_pos;
    logic [IDX_W-1:0]   hit_idx;
    logic               last_word;

    assign accept = i_start && !o_busy;
    assign o_busy = (r_state != S_IDLE);

    // Borrow out of the subtract means the value sits below the base.
    assign diff   = {1'b0, i_value} - {1'b0, r_base};
    assign ins_ok = !diff[VAL_W] && ({1'b0, diff} < (VAL_W+2)'(RANGE_BITS));

    assign masked    = r_first ? (rdata & ({WORD_W{1'b1}} << r_cursor[BIT_W-1:0]))
                               : rdata;
    assign hit_pos   = lowest_bit(masked);
    assign hit_idx   = IDX_W'({r_chk_word, hit_pos});
    assign last_word = (r_chk_word == WADDR_W'(WORD_CNT - 1));

    always_comb begin
        case (r_state)
            S_SCAN:  raddr = r_chk_word + WADDR_W'(1);
            S_IDLE:  raddr = (i_kind == KIND_FETCH) ? r_cursor[IDX_W-1:BIT_W]
                                                    : diff[IDX_W-1:BIT_W];
            default: raddr = r_ins_idx[IDX_W-1:BIT_W];
        endcase
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_ins_idx[IDX_W-1:BIT_W];
        wdata = rdata | (WORD_W'(1) << r_ins_idx[BIT_W-1:0]);
        case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr_addr;
                wdata = '0;
            end
            S_INS: begin
                we = 1'b1;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    bms_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_cfg_we) begin
            r_base <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_cursor   <= '0;
            r_strobe   <= 1'b0;
            r_first    <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + WADDR_W'(1);
                    if (r_clr_addr == WADDR_W'(WORD_CNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        if (i_kind == KIND_FETCH) begin
                            if (r_cursor[IDX_W]) begin
                                // scan already ended: answer at once
                                r_strobe <= 1'b1;
                                r_sorted <= '0;
                                r_found  <= 1'b0;
                            end else begin
                                r_chk_word <= r_cursor[IDX_W-1:BIT_W];
                                r_first    <= 1'b1;
                                r_state    <= S_SCAN;
                            end
                        end else if (ins_ok) begin
                            r_ins_idx <= diff[IDX_W-1:0];
                            r_state   <= S_INS;
                        end
                    end
                end
                S_INS: begin
                    r_state <= S_IDLE;
                end
                S_SCAN: begin
                    r_first <= 1'b0;
                    if (masked != '0) begin
                        r_strobe <= 1'b1;
                        r_sorted <= r_base + VAL_W'(hit_idx);
                        r_found  <= 1'b1;
                        r_cursor <= CUR_W'(hit_idx) + CUR_W'(1);
                        r_state  <= S_IDLE;
                    end else if (last_word) begin
                        r_strobe <= 1'b1;
                        r_sorted <= '0;
                        r_found  <= 1'b0;
                        r_cursor <= CUR_W'(RANGE_BITS);
                        r_state  <= S_IDLE;
                    end else begin
                        // advance; the next word's read is already issued
                        r_chk_word <= r_chk_word + WADDR_W'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe       = r_strobe;
    assign o_sorted_value = r_sorted;
    assign o_found        = r_found;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Bench for the bitmap sorter. A short table of hand-picked transactions comes
// first; random phases under different base offsets follow. A bit-level copy
// of the bitmap and scan cursor inside the bench predicts each fetch result that the table does not give.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bms_pkg::*;

    localparam int unsigned QUIET_LIMIT = 10000;
    localparam int unsigned DIR_ROWS    = 24;
    localparam int unsigned PHASES      = 12;
    localparam int unsigned PHASE_ITEMS = 100;
    localparam logic [VAL_W-1:0] VAL_MAX = '1;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             found;
    } t_sorted;

    typedef struct packed {
        bit               is_cfg;
        logic             kind;
        logic [VAL_W-1:0] value;
        bit               typed;
        logic [VAL_W-1:0] t_value;
        logic             t_found;
    } t_stim_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_start;
    logic             i_kind;
    logic [VAL_W-1:0] i_value;
    logic             i_cfg_we;
    logic [VAL_W-1:0] i_cfg_data;
    logic             o_busy;
    logic             o_strobe;
    logic [VAL_W-1:0] o_sorted_value;
    logic             o_found;

    // Bench copy of the sorter state.
    bit               presence_map [RANGE_BITS];
    int unsigned      scan_pos;
    logic [VAL_W-1:0] base_reg;
    logic [VAL_W-1:0] last_insert;
    t_sorted          sorted_due [$];
    int unsigned      error_count;

    t_stim_row opening_rows [DIR_ROWS] = '{
        '{1'b0, KIND_INSERT, 24'd0,       1'b0, 24'd0,      1'b0},
        '{1'b0, KIND_INSERT, 24'd5,       1'b0, 24'd0,      1'b0},
        '{1'b0, KIND_INSERT, 24'd5,       1'b0, 24'd0,      1'b0},
        '{1'b0, KIND_INSERT, 24'hFFFFFF,  1'b0, 24'd0,      1'b0},
        '{1'b0, KIND_INSERT, 24'd65536,   1'b0, 24'd0,      1'b0},
        '{1'b0, KIND_FETCH,  24'd0,       1'b1, 24'd0,      1'b1},
        '{1'b0, KIND_FETCH,  24'hFFFFFF,  1'b1, 24'd5,      1'b1},
        '{1'b0, KIND_INSERT, 24'd3,       1'b0, 24'd0,      1'b0},
        '{1'b0, KIND_INSERT, 24'd40,      1'b0, 24'd0,      1'b0},
        '{1'b0, KIND_FETCH,  24'd0,       1'b1, 24'd40,     1'b1},
        '{1'b1, KIND_INSERT, 24'd100,     1'b0, 24'd0,      1'b0},
        '{1'b0, KIND_INSERT, 24'd99,      1'b0, 24'd0,      1'b0},
        '{1'b0, KIND_INSERT, 24'd150,     1'b0, 24'd0,      1'b0},
        '{1'b0, KIND_INSERT, 24'd65635,   1'b0, 24'd0,      1'b0},
        '{1'b0, KIND_FETCH,  24'd0,       1'b1, 24'd150,    1'b1},
        '{1'b1, KIND_INSERT, 24'hFFFFFF,  1'b0, 24'd0,      1'b0},
        '{1'b0, KIND_INSERT, 24'd0,       1'b0, 24'd0,      1'b0},
        '{1'b0, KIND_INSERT, 24'hFFFFFF,  1'b0, 24'd0,      1'b0},
        '{1'b1, KIND_INSERT, 24'hFFFF00,  1'b0, 24'd0,      1'b0},
        '{1'b0, KIND_INSERT, 24'hFFFFC0,  1'b0, 24'd0,      1'b0},
        '{1'b1, KIND_INSERT, 24'hFFFFF0,  1'b0, 24'd0,      1'b0},
        '{1'b0, KIND_FETCH,  24'd0,       1'b1, 24'h0000B0, 1'b1},
        '{1'b1, KIND_INSERT, 24'd0,       1'b0, 24'd0,      1'b0},
        '{1'b0, KIND_INSERT, 24'd1000,    1'b0, 24'd0,      1'b0}
    };

    bitmap_sort uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_kind         (i_kind),
        .i_value        (i_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_sorted_value (o_sorted_value),
        .o_found        (o_found)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // Apply one accepted transaction to the bench bitmap; fetches yield a result.
    task automatic predict_sorted(input logic kind, input logic [VAL_W-1:0] value,
                                  output bit gives, output t_sorted res);
        int unsigned idx;
        gives = 1'b0;
        res   = '0;
        if (kind == KIND_INSERT) begin
            if (value >= base_reg) begin
                idx = value - base_reg;
                if (idx < RANGE_BITS) begin
                    presence_map[idx] = 1'b1;
                end
            end
        end else begin
            gives = 1'b1;
            while (scan_pos < RANGE_BITS && !presence_map[scan_pos]) begin
                scan_pos++;
            end
            if (scan_pos < RANGE_BITS) begin
                res.value = base_reg + VAL_W'(scan_pos);
                res.found = 1'b1;
                scan_pos++;
            end
        end
    endtask

    task automatic send_item(input logic kind, input logic [VAL_W-1:0] value,
                             input bit typed, input logic [VAL_W-1:0] t_value,
                             input logic t_found);
        bit      gives;
        t_sorted res;
        i_start <= 1'b1;
        i_kind  <= kind;
        i_value <= value;
        @(posedge i_clk);
        while (o_busy) begin
            @(posedge i_clk);
        end
        predict_sorted(kind, value, gives, res);
        if (typed) begin
            res.value = t_value;
            res.found = t_found;
        end
        if (gives) begin
            sorted_due = {sorted_due, res};
        end
        if (kind == KIND_INSERT) begin
            last_insert = value;
        end
        @(negedge i_clk);
    endtask

    task automatic idle_burst();
        i_start <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge i_clk);
    endtask

    // Hold off until every fetch has answered and the last insert has retired.
    task automatic wait_for_results();
        i_start <= 1'b0;
        while (sorted_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
        while (o_busy) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_base(input logic [VAL_W-1:0] v);
        wait_for_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        base_reg    = v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic run_phase(input logic [VAL_W-1:0] pbase, input int unsigned spread,
                             input int unsigned idle_pct);
        int unsigned      r;
        int unsigned      idx;
        logic             k;
        logic [VAL_W-1:0] v;
        write_base(pbase);
        repeat (PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            k = KIND_INSERT;
            v = VAL_W'($urandom);
            if (r < 35) begin
                k = KIND_FETCH;
            end else if (r < 80) begin
                // land just ahead of the cursor so later fetches find it
                idx = scan_pos + $urandom_range(0, spread);
                if (idx < RANGE_BITS && base_reg + idx <= VAL_MAX) begin
                    v = base_reg + VAL_W'(idx);
                end
            end else if (r < 85) begin
                v = last_insert;
            end else if (r < 90) begin
                if (base_reg != 0) begin
                    v = VAL_W'($urandom_range(0, base_reg - 1));
                end
            end else if (r < 95) begin
                if (scan_pos > 0) begin
                    v = base_reg + VAL_W'($urandom_range(0, scan_pos - 1));
                end
            end else if (r < 97) begin
                v = base_reg + VAL_W'(RANGE_BITS + $urandom_range(0, 255));
            end
            send_item(k, v, 1'b0, '0, 1'b0);
            if ($urandom_range(0, 99) < idle_pct) begin
                idle_burst();
            end else if ($urandom_range(0, 199) == 0) begin
                wait_for_results();
            end
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_sorted want;
        if (i_rst_n && o_strobe) begin
            if (sorted_due.size() == 0) begin
                report_mismatch($sformatf("result %h found=%b with nothing pending",
                                          o_sorted_value, o_found));
            end else begin
                want = sorted_due.pop_front();
                if (o_sorted_value !== want.value) begin
                    report_mismatch($sformatf("sorted_value %h, want %h",
                                              o_sorted_value, want.value));
                end
                if (o_found !== want.found) begin
                    report_mismatch($sformatf("found %b, want %b", o_found, want.found));
                end
            end
        end
    end

    // End the run when no transaction moves for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_start && !o_busy) || o_strobe || i_cfg_we) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_top: errors");
        $finish;
    end

    initial begin : stimulus
        logic [VAL_W-1:0] pbase;
        int unsigned      spread;
        int unsigned      idle_pct;
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_kind      = KIND_INSERT;
        i_value     = '0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        base_reg    = '0;
        last_insert = '0;
        scan_pos    = 0;
        error_count = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening_rows[n]) begin
            if (opening_rows[n].is_cfg) begin
                write_base(opening_rows[n].value);
            end else begin
                send_item(opening_rows[n].kind, opening_rows[n].value, opening_rows[n].typed,
                          opening_rows[n].t_value, opening_rows[n].t_found);
            end
        end

        for (int unsigned p = 0; p < PHASES; p++) begin
            case (p % 6)
                0: pbase = '0;
                1: pbase = VAL_W'($urandom);
                2: pbase = VAL_MAX;
                3: pbase = VAL_MAX - VAL_W'($urandom_range(0, 65535));
                4: pbase = VAL_W'($urandom_range(1, 4095));
                default: pbase = VAL_W'($urandom_range(0, 255));
            endcase
            case (p % 4)
                0: spread = 16;
                1: spread = 128;
                2: spread = 1024;
                default: spread = 4096;
            endcase
            idle_pct = (p >= PHASES - 2) ? 0 : (p % 3) * 25;
            run_phase(pbase, spread, idle_pct);
        end

        // Drain the bitmap to the end of the scan, then confirm it stays finished.
        write_base(VAL_W'($urandom));
        while (scan_pos < RANGE_BITS) begin
            send_item(KIND_FETCH, VAL_W'($urandom), 1'b0, '0, 1'b0);
        end
        repeat (3) send_item(KIND_FETCH, VAL_W'($urandom), 1'b0, '0, 1'b0);

        i_start <= 1'b0;
        while (sorted_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
        if (error_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/bms_pkg.sv
hw/rtl/bms_ram.sv
hw/rtl/bitmap_sort.sv
tb/tb_top.sv
